// ===== src/rss_pkg.sv =====
// shared types, codes and reset values of the robot safety supervisor
`timescale 1ns / 1ps

package rss_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_WARN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_SAFE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLT_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLT_VALID = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STREAK     = 3'd5;

  // register reset values
  localparam logic [15:0] STALE_WARN_RST  = 16'd200;
  localparam logic [15:0] STALE_SAFE_RST  = 16'd1000;
  localparam logic [10:0] TEMP_LIMIT_RST  = 11'd700;
  localparam logic [14:0] VOLT_LOW_RST    = 15'd10000;
  localparam logic [14:0] VOLT_VALID_RST  = 15'd100;
  localparam logic [7:0]  STREAK_RST      = 8'd3;

  localparam logic [7:0]  STREAK_MAX      = 8'hFF;

  // sticky fault events
  localparam logic [1:0] EVT_NONE     = 2'd0;
  localparam logic [1:0] EVT_CHECKSUM = 2'd1;
  localparam logic [1:0] EVT_TARGET   = 2'd2;

  typedef enum logic [1:0] {
    MODE_REST  = 2'd0,
    MODE_TRACK = 2'd1,
    MODE_KEEP  = 2'd2,
    MODE_CALIB = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_APPLY = 2'd1,
    ACT_HOLD  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    FAULT_CLEAR    = 3'd0,
    FAULT_POSTURE  = 3'd1,
    FAULT_TEMP     = 3'd2,
    FAULT_VOLT     = 3'd3,
    FAULT_STALE    = 3'd4,
    FAULT_CHECKSUM = 3'd5,
    FAULT_TARGET   = 3'd6
  } fault_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        cmd_arrived;
    logic [2:0]  requested_mode;
    logic        attitude_ok;
    logic [10:0] hottest_temp;
    logic [14:0] bus_voltage_mv;
    logic [1:0]  sticky_event;
    logic        target_valid;
  } in_item_t;

  typedef struct packed {
    mode_t   drive_mode;
    logic    torque_active;
    logic    torque_on_pulse;
    logic    torque_off_pulse;
    action_t joint_action;
    fault_t  fault_status;
    logic    cmd_fresh;
    logic    in_safe_state;
    logic    calibrating;
  } out_item_t;

  typedef struct packed {
    mode_t       current_mode;
    logic        torque_on;
    fault_t      fault_held;
    logic [31:0] last_command_time;
    logic        fresh_flag;
    logic [7:0]  temp_streak;
    logic [7:0]  volt_streak;
  } state_t;

  typedef struct packed {
    logic [15:0] age_warn_ms;
    logic [15:0] age_safe_ms;
    logic [10:0] temp_limit;
    logic [14:0] volt_low_mv;
    logic [14:0] volt_valid_mv;
    logic [7:0]  streak_needed;
  } cfg_t;

endpackage

// ===== src/rss_if.sv =====
// valid/ready channels for control ticks and supervisor results
`timescale 1ns / 1ps

interface rss_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        cmd_arrived;
  logic [2:0]  requested_mode;
  logic        attitude_ok;
  logic [10:0] hottest_temp;
  logic [14:0] bus_voltage_mv;
  logic [1:0]  sticky_event;
  logic        target_valid;

  modport source (
    output valid, now_ms, cmd_arrived, requested_mode, attitude_ok,
           hottest_temp, bus_voltage_mv, sticky_event, target_valid,
    input  ready
  );
  modport sink (
    input  valid, now_ms, cmd_arrived, requested_mode, attitude_ok,
           hottest_temp, bus_voltage_mv, sticky_event, target_valid,
    output ready
  );
endinterface

interface rss_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] drive_mode;
  logic       torque_active;
  logic       torque_on_pulse;
  logic       torque_off_pulse;
  logic [1:0] joint_action;
  logic [2:0] fault_status;
  logic       cmd_fresh;
  logic       in_safe_state;
  logic       calibrating;

  modport source (
    output valid, drive_mode, torque_active, torque_on_pulse, torque_off_pulse,
           joint_action, fault_status, cmd_fresh, in_safe_state, calibrating,
    input  ready
  );
  modport sink (
    input  valid, drive_mode, torque_active, torque_on_pulse, torque_off_pulse,
           joint_action, fault_status, cmd_fresh, in_safe_state, calibrating,
    output ready
  );
endinterface

// ===== src/rss_step.sv =====
// one control tick: staleness, fault priority, streaks and mode dispatch
`timescale 1ns / 1ps

module rss_step (
  input  rss_pkg::cfg_t      cfg,
  input  rss_pkg::state_t    st,
  input  rss_pkg::in_item_t  item,
  output rss_pkg::state_t    st_nxt,
  output rss_pkg::out_item_t res
);
  import rss_pkg::*;

  mode_t       mode_arr;
  mode_t       mode_eff;
  fault_t      held_evt;
  fault_t      trans_fault;
  logic [31:0] lct;
  logic [31:0] age;
  logic        warn;
  logic        safe;
  logic        fresh;
  logic        temp_over;
  logic [7:0]  temp_inc;
  logic        temp_fault;
  logic        volt_cnt;
  logic [7:0]  volt_inc;
  logic        volt_fault;
  logic        torque;
  action_t     action;

  always_comb begin
    // command intake
    if (item.cmd_arrived) begin
      lct      = item.now_ms;
      mode_arr = item.requested_mode[2] ? MODE_REST : mode_t'(item.requested_mode[1:0]);
    end else begin
      lct      = st.last_command_time;
      mode_arr = st.current_mode;
    end

    priority if (item.sticky_event == EVT_CHECKSUM) begin
      held_evt = FAULT_CHECKSUM;
    end else if (item.sticky_event == EVT_TARGET) begin
      held_evt = FAULT_TARGET;
    end else begin
      held_evt = st.fault_held;
    end

    // age wraps modulo 2^32
    age   = item.now_ms - lct;
    warn  = age > {16'd0, cfg.age_warn_ms};
    safe  = age > {16'd0, cfg.age_safe_ms};
    fresh = (item.cmd_arrived || st.fresh_flag) && !warn;

    temp_over  = item.hottest_temp > cfg.temp_limit;
    temp_inc   = (st.temp_streak == STREAK_MAX) ? st.temp_streak : st.temp_streak + 8'd1;
    temp_fault = temp_over && (temp_inc >= cfg.streak_needed);

    // voltage only counts when temperature did not already raise a fault
    volt_cnt   = !temp_fault && (item.bus_voltage_mv > cfg.volt_valid_mv)
                 && (item.bus_voltage_mv < cfg.volt_low_mv);
    volt_inc   = (st.volt_streak == STREAK_MAX) ? st.volt_streak : st.volt_streak + 8'd1;
    volt_fault = volt_cnt && (volt_inc >= cfg.streak_needed);

    priority if (temp_fault) begin
      trans_fault = FAULT_TEMP;
    end else if (volt_fault) begin
      trans_fault = FAULT_VOLT;
    end else if (warn) begin
      trans_fault = FAULT_STALE;
    end else begin
      trans_fault = FAULT_CLEAR;
    end

    st_nxt                   = st;
    st_nxt.last_command_time = lct;
    st_nxt.fresh_flag        = fresh;

    if (!item.attitude_ok) begin
      // posture trip keeps the streaks
      mode_eff          = MODE_REST;
      st_nxt.fault_held = FAULT_POSTURE;
    end else begin
      mode_eff           = safe ? MODE_REST : mode_arr;
      st_nxt.temp_streak = temp_over ? temp_inc : 8'd0;
      st_nxt.volt_streak = volt_cnt ? volt_inc : 8'd0;
      if ((held_evt == FAULT_CHECKSUM || held_evt == FAULT_TARGET)
          && trans_fault == FAULT_CLEAR) begin
        st_nxt.fault_held = held_evt;
      end else begin
        st_nxt.fault_held = trans_fault;
      end
    end

    unique case (mode_eff)
      MODE_TRACK: begin
        torque = 1'b1;
        action = item.target_valid ? ACT_APPLY : ACT_HOLD;
      end
      MODE_KEEP: begin
        torque = 1'b1;
        action = ACT_HOLD;
      end
      MODE_REST, MODE_CALIB: begin
        torque = 1'b0;
        action = ACT_NONE;
      end
      default: begin
        torque = 1'b0;
        action = ACT_NONE;
      end
    endcase

    st_nxt.current_mode = mode_eff;
    st_nxt.torque_on    = torque;

    res.drive_mode       = mode_eff;
    res.torque_active    = torque;
    res.torque_on_pulse  = !st.torque_on && torque;
    res.torque_off_pulse = st.torque_on && !torque;
    res.joint_action     = action;
    res.fault_status     = st_nxt.fault_held;
    res.cmd_fresh        = fresh;
    res.in_safe_state    = !item.attitude_ok;
    res.calibrating      = mode_eff == MODE_CALIB;
  end

endmodule

// ===== src/robot_safety_supervisor_core.sv =====
// robot safety supervisor top level: channels, registers and tick state
`timescale 1ns / 1ps

// Robot safety supervisor. Each input transaction is one control tick; it yields exactly
// one result transaction. A tick is taken into an input register, evaluated against the
// supervisor state in a single pass, and its result lands in an output register when that
// register is free or being emptied. One tick is accepted every cycle as long
// as the result side keeps taking results; the state update of one tick is complete before
// the next tick is evaluated. Configuration writes take effect at the next clock edge and
// are meant to be made while no tick is in flight. No clearing pass after reset.
module robot_safety_supervisor_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rss_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  rss_in_if.sink                            in_item,
  rss_out_if.source                         out_item
);
  import rss_pkg::*;

  cfg_t      cfg_r;
  state_t    st_r;
  state_t    st_nxt;
  in_item_t  in_data_r;
  logic      in_valid_r;
  out_item_t out_data_r;
  out_item_t res;
  logic      out_valid_r;
  logic      advance;

  assign advance       = in_valid_r && (!out_valid_r || out_item.ready);
  // no transaction is taken while reset is held
  assign in_item.ready = rst_n && (!in_valid_r || advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_item.ready) begin
      in_valid_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      in_data_r.now_ms         <= in_item.now_ms;
      in_data_r.cmd_arrived    <= in_item.cmd_arrived;
      in_data_r.requested_mode <= in_item.requested_mode;
      in_data_r.attitude_ok    <= in_item.attitude_ok;
      in_data_r.hottest_temp   <= in_item.hottest_temp;
      in_data_r.bus_voltage_mv <= in_item.bus_voltage_mv;
      in_data_r.sticky_event   <= in_item.sticky_event;
      in_data_r.target_valid   <= in_item.target_valid;
    end
  end

  rss_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (in_data_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.current_mode      <= MODE_REST;
      st_r.torque_on         <= 1'b0;
      st_r.fault_held        <= FAULT_CLEAR;
      st_r.last_command_time <= 32'd0;
      st_r.fresh_flag        <= 1'b0;
      st_r.temp_streak       <= 8'd0;
      st_r.volt_streak       <= 8'd0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_item.ready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.age_warn_ms   <= STALE_WARN_RST;
      cfg_r.age_safe_ms   <= STALE_SAFE_RST;
      cfg_r.temp_limit    <= TEMP_LIMIT_RST;
      cfg_r.volt_low_mv   <= VOLT_LOW_RST;
      cfg_r.volt_valid_mv <= VOLT_VALID_RST;
      cfg_r.streak_needed <= STREAK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STALE_WARN: cfg_r.age_warn_ms   <= cfg_wdata;
        CFG_STALE_SAFE: cfg_r.age_safe_ms   <= cfg_wdata;
        CFG_TEMP_LIMIT: cfg_r.temp_limit    <= cfg_wdata[10:0];
        CFG_VOLT_LOW:   cfg_r.volt_low_mv   <= cfg_wdata[14:0];
        CFG_VOLT_VALID: cfg_r.volt_valid_mv <= cfg_wdata[14:0];
        CFG_STREAK:     cfg_r.streak_needed <= cfg_wdata[7:0];
        default: begin
          // unused indexes are dropped
        end
      endcase
    end
  end

  assign out_item.valid            = out_valid_r;
  assign out_item.drive_mode       = out_data_r.drive_mode;
  assign out_item.torque_active    = out_data_r.torque_active;
  assign out_item.torque_on_pulse  = out_data_r.torque_on_pulse;
  assign out_item.torque_off_pulse = out_data_r.torque_off_pulse;
  assign out_item.joint_action     = out_data_r.joint_action;
  assign out_item.fault_status     = out_data_r.fault_status;
  assign out_item.cmd_fresh        = out_data_r.cmd_fresh;
  assign out_item.in_safe_state    = out_data_r.in_safe_state;
  assign out_item.calibrating      = out_data_r.calibrating;

endmodule

// ===== src/rss_checker.sv =====
// result-side checks of the safety supervisor, bound to the top level
`timescale 1ns / 1ps

module rss_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] drive_mode,
  input logic       torque_active,
  input logic       torque_on_pulse,
  input logic       torque_off_pulse,
  input logic [1:0] joint_action,
  input logic [2:0] fault_status,
  input logic       in_safe_state,
  input logic       calibrating
);
  import rss_pkg::*;

  // no result can be pending right after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result keeps its payload
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(drive_mode) && $stable(fault_status)
      && $stable(torque_active) && $stable(joint_action))
    else $error("stalled result changed");

  // posture trip forces idle, torque off, no joint action and the posture fault
  a_safe_trip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && in_safe_state |-> drive_mode == MODE_REST && !torque_active
      && joint_action == ACT_NONE && fault_status == FAULT_POSTURE)
    else $error("posture trip not enforced");

  // torque follows the mode and its edges agree with the level
  a_torque_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (torque_active == (drive_mode == MODE_TRACK || drive_mode == MODE_KEEP))
      && !(torque_on_pulse && !torque_active) && !(torque_off_pulse && torque_active)
      && (calibrating == (drive_mode == MODE_CALIB)))
    else $error("torque state disagrees with mode");

  // a torque on edge never follows a delivered result with torque already on
  a_pulse_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && torque_active ##1 out_valid |-> !torque_on_pulse)
    else $error("torque on edge while already on");

endmodule

bind robot_safety_supervisor_core rss_checker u_rss_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_item.valid),
  .out_ready        (out_item.ready),
  .drive_mode       (out_item.drive_mode),
  .torque_active    (out_item.torque_active),
  .torque_on_pulse  (out_item.torque_on_pulse),
  .torque_off_pulse (out_item.torque_off_pulse),
  .joint_action     (out_item.joint_action),
  .fault_status     (out_item.fault_status),
  .in_safe_state    (out_item.in_safe_state),
  .calibrating      (out_item.calibrating)
);
